// File: rtl/core/mie_pkg.sv
// Package for the MIPS32 execute unit: opcodes, sizes, sequencer states.
// No dependencies.
`default_nettype none
package mie_pkg;
	localparam int DATA_WORDS = 1024;
	localparam int DW_BITS = $clog2(DATA_WORDS);

	typedef enum logic [1:0] {OP_EXEC = 2'd0, OP_WRITE = 2'd1, OP_READ = 2'd2,
		OP_NONE = 2'd3} op_t;

	typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_MEM, ST_MDU, ST_DONE} state_t;

	typedef enum logic [1:0] {FLT_NONE = 2'd0, FLT_UNKNOWN = 2'd1,
		FLT_DIVZERO = 2'd2} fault_t;

	// primary opcodes
	localparam logic [5:0] OPC_SPECIAL = 6'h00, OPC_REGIMM = 6'h01, OPC_J = 6'h02,
		OPC_JAL = 6'h03, OPC_BEQ = 6'h04, OPC_BNE = 6'h05, OPC_BLEZ = 6'h06,
		OPC_BGTZ = 6'h07, OPC_ADDI = 6'h08, OPC_ADDIU = 6'h09, OPC_SLTI = 6'h0A,
		OPC_SLTIU = 6'h0B, OPC_ANDI = 6'h0C, OPC_ORI = 6'h0D, OPC_XORI = 6'h0E,
		OPC_LUI = 6'h0F, OPC_LB = 6'h20, OPC_LH = 6'h21, OPC_LW = 6'h23,
		OPC_LBU = 6'h24, OPC_LHU = 6'h25, OPC_SB = 6'h28, OPC_SH = 6'h29,
		OPC_SW = 6'h2B;
	// SPECIAL function codes
	localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03,
		FN_SLLV = 6'h04, FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08,
		FN_JALR = 6'h09, FN_SYSCALL = 6'h0C, FN_MFHI = 6'h10, FN_MTHI = 6'h11,
		FN_MFLO = 6'h12, FN_MTLO = 6'h13, FN_MULT = 6'h18, FN_MULTU = 6'h19,
		FN_DIV = 6'h1A, FN_DIVU = 6'h1B, FN_ADD = 6'h20, FN_ADDU = 6'h21,
		FN_SUB = 6'h22, FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25,
		FN_XOR = 6'h26, FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B;
	// REGIMM rt codes
	localparam logic [4:0] RT_BLTZ = 5'h00, RT_BGEZ = 5'h01, RT_BLTZAL = 5'h10,
		RT_BGEZAL = 5'h11;
	localparam logic [4:0] REG_V0 = 5'd2, REG_RA = 5'd31;
	localparam logic [31:0] EXIT_CODE = 32'h0000_000A;

	// multiply/divide unit command and status
	typedef enum logic [1:0] {MD_MULT, MD_MULTU, MD_DIV, MD_DIVU} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t kind;
	} md_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/mie_mdu.sv
// Iterative multiply/divide unit: one bit of the product or quotient per cycle.
// Depends on mie_pkg.
`default_nettype none
module mie_mdu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mie_pkg::md_cmd_t  cmd,
	input  wire logic [31:0]       a,
	input  wire logic [31:0]       b,
	output mie_pkg::md_stat_t      stat
);
	import mie_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	md_op_t      kind_q;
	logic        neg_q_q, neg_r_q;
	logic [31:0] acc_q;   // partial high part / remainder
	logic [31:0] sh_q;    // multiplier / dividend bits, becomes low / quotient
	logic [31:0] m_q;     // multiplicand / divisor magnitude
	logic        fin_q;

	logic        sgn;
	logic [31:0] ma, mb;
	logic [32:0] add_sum;
	logic [32:0] trial;
	logic [63:0] prod;
	logic [63:0] nprod;
	logic [31:0] qf, rf;

	assign sgn = (cmd.kind == MD_MULT) || (cmd.kind == MD_DIV);
	assign ma = (sgn && a[31]) ? (32'd0 - a) : a;
	assign mb = (sgn && b[31]) ? (32'd0 - b) : b;
	assign add_sum = {1'b0, acc_q} + {1'b0, m_q};
	assign trial = {acc_q, sh_q[31]} - {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			kind_q <= cmd.kind;
			acc_q <= '0;
			sh_q <= ma;
			m_q <= mb;
			neg_q_q <= sgn && (a[31] ^ b[31]);
			neg_r_q <= sgn && a[31];
		end else if (busy_q) begin
			if (kind_q == MD_MULT || kind_q == MD_MULTU) begin
				// shift-add: add when the low multiplier bit is set
				if (sh_q[0]) begin
					{acc_q, sh_q} <= {add_sum, sh_q[31:1]};
				end else begin
					{acc_q, sh_q} <= {1'b0, acc_q, sh_q[31:1]};
				end
			end else begin
				// restoring division, one quotient bit per cycle
				if (!trial[32]) begin
					acc_q <= trial[31:0];
					sh_q <= {sh_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], sh_q[31]};
					sh_q <= {sh_q[30:0], 1'b0};
				end
			end
		end
	end

	assign prod = {acc_q, sh_q};
	assign nprod = neg_q_q ? (64'd0 - prod) : prod;
	assign qf = neg_q_q ? (32'd0 - sh_q) : sh_q;
	assign rf = neg_r_q ? (32'd0 - acc_q) : acc_q;

	always_comb begin
		stat.done = fin_q;
		if (kind_q == MD_MULT || kind_q == MD_MULTU) begin
			stat.hi = nprod[63:32];
			stat.lo = nprod[31:0];
		end else begin
			stat.hi = rf;
			stat.lo = qf;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/mips32_instruction_execute_unit.sv
// Top level of the MIPS32 execute unit: sequencer, register file, data store.
// Depends on mie_pkg and mie_mdu.
`default_nettype none
// Takes one transaction at a time. A data write, an unused op, an ignored
// execute after halt, and ALU, branch, jump and unknown instructions pass
// through capture, execute and result; data reads, loads and stores add a
// state for the single-port data store read; MULT, MULTU, DIV, DIVU add the
// bit-serial multiply/divide unit (a divide by zero skips the unit). The result
// is held in an output register until taken; s_tready stays low until then, and
// the next transaction can be accepted in the cycle after the result is taken.
// Writing start_address loads the PC.
// tdata in: op[1:0], instr[33:2], data_addr[65:34], data_word[97:66], zero pad.
// tdata out: next_pc[31:0], halted[32], fault[34:33], reg_written[35],
// reg_index[40:36], reg_value[72:41], read_word[104:73], zero pad.
module mips32_instruction_execute_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,  // op, instr, data_addr, data_word
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata   // next_pc, halted, fault, reg_written,
	                                    // reg_index, reg_value, read_word
);
	import mie_pkg::*;

	state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [31:0] ins_q, daddr_q, dword_q;
	logic [31:0] pc_q, hi_q, lo_q;
	logic        stop_q;
	logic [31:0] rf_q [32];
	logic [31:0] mem [DATA_WORDS];
	logic [31:0] a_q, b_q, mrd_q;
	logic [DW_BITS-1:0] wi_q;
	logic [1:0]  lo2_q;

	// result register
	logic [31:0] o_pc_q, o_rv_q, o_rw_q;
	logic        o_halt_q, o_wr_q;
	logic [1:0]  o_flt_q;
	logic [4:0]  o_ri_q;

	md_cmd_t  md_cmd;
	md_stat_t md_stat;

	logic [5:0]  opc, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] simm, zimm, pc4, btgt, jtgt, addr;
	logic        is_mem, is_md;

	assign opc = ins_q[31:26];
	assign rs = ins_q[25:21];
	assign rt = ins_q[20:16];
	assign rd = ins_q[15:11];
	assign sa = ins_q[10:6];
	assign fn = ins_q[5:0];
	assign zimm = {16'd0, ins_q[15:0]};
	assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
	assign pc4 = pc_q + 32'd4;
	assign btgt = pc4 + {simm[29:0], 2'b00};
	assign jtgt = {pc_q[31:28], ins_q[25:0], 2'b00};
	assign addr = a_q + simm;

	assign is_mem = (op_q == OP_EXEC) && !stop_q && (opc inside {OPC_LB, OPC_LH, OPC_LW,
		OPC_LBU, OPC_LHU, OPC_SB, OPC_SH, OPC_SW});
	assign is_md = (op_q == OP_EXEC) && !stop_q && (opc == OPC_SPECIAL) &&
		(fn inside {FN_MULT, FN_MULTU, FN_DIV, FN_DIVU}) && !(fn[1] && b_q == 32'd0);

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid && s_tready) state_d = ST_DECODE;
			ST_DECODE: begin
				if (op_q == OP_WRITE || op_q == OP_NONE) state_d = ST_DONE;
				else if (is_mem || op_q == OP_READ) state_d = ST_MEM;
				else if (is_md) state_d = ST_MDU;
				else state_d = ST_DONE;
			end
			ST_MEM:    state_d = ST_DONE;
			ST_MDU:    if (md_stat.done) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs to the multiply/divide unit
	always_comb begin
		md_cmd.start = (state_q == ST_DECODE) && is_md;
		case (fn[1:0])
			2'b00:   md_cmd.kind = MD_MULT;
			2'b01:   md_cmd.kind = MD_MULTU;
			2'b10:   md_cmd.kind = MD_DIV;
			default: md_cmd.kind = MD_DIVU;
		endcase
	end

	mie_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd),
		.a      (a_q),
		.b      (b_q),
		.stat   (md_stat)
	);

	// execute: compute the architectural effect of the held instruction
	logic [31:0] nxt, wv, memw, lval;
	logic [4:0]  widx;
	logic        wen, mwe, hwe, lwe, halt_set;
	logic [1:0]  flt;
	logic [4:0]  lane;
	logic [4:0]  shamt;
	logic [31:0] sft_l, sft_r, sft_a;

	assign shamt = fn[2] ? a_q[4:0] : sa;
	assign sft_l = b_q << shamt;
	assign sft_r = b_q >> shamt;
	assign sft_a = $unsigned($signed(b_q) >>> shamt);
	assign lane = {lo2_q, 3'b000};

	always_comb begin
		nxt = pc4;
		wv = '0;
		widx = rd;
		wen = 1'b0;
		mwe = 1'b0;
		memw = b_q;
		hwe = 1'b0;
		lwe = 1'b0;
		halt_set = 1'b0;
		flt = FLT_NONE;
		lval = mrd_q;
		case (opc)
			OPC_SPECIAL: begin
				wen = 1'b1;
				case (fn)
					FN_ADD, FN_ADDU: wv = a_q + b_q;
					FN_SUB, FN_SUBU: wv = a_q - b_q;
					FN_AND: wv = a_q & b_q;
					FN_OR: wv = a_q | b_q;
					FN_XOR: wv = a_q ^ b_q;
					FN_NOR: wv = ~(a_q | b_q);
					FN_SLT: wv = {31'd0, $signed(a_q) < $signed(b_q)};
					FN_SLTU: wv = {31'd0, a_q < b_q};
					FN_SLL, FN_SLLV: wv = sft_l;
					FN_SRL, FN_SRLV: wv = sft_r;
					FN_SRA, FN_SRAV: wv = sft_a;
					FN_JR: begin wen = 1'b0; nxt = a_q; end
					FN_JALR: begin nxt = a_q; wv = pc4; end
					FN_MFHI: wv = hi_q;
					FN_MFLO: wv = lo_q;
					FN_MTHI: begin wen = 1'b0; hwe = 1'b1; end
					FN_MTLO: begin wen = 1'b0; lwe = 1'b1; end
					FN_MULT, FN_MULTU: wen = 1'b0;
					FN_DIV, FN_DIVU: begin
						wen = 1'b0;
						if (b_q == 32'd0) flt = FLT_DIVZERO;
					end
					FN_SYSCALL: begin wen = 1'b0; halt_set = (rf_q[REG_V0] == EXIT_CODE); end
					default: begin wen = 1'b0; flt = FLT_UNKNOWN; end
				endcase
			end
			OPC_J: nxt = jtgt;
			OPC_JAL: begin nxt = jtgt; wen = 1'b1; widx = REG_RA; wv = pc4; end
			OPC_REGIMM: begin
				if (rt inside {RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL}) begin
					if (rt[4]) begin wen = 1'b1; widx = REG_RA; wv = pc4; end
					if (a_q[31] ^ rt[0]) nxt = btgt;
				end else begin
					flt = FLT_UNKNOWN;
				end
			end
			OPC_BEQ: if (a_q == b_q) nxt = btgt;
			OPC_BNE: if (a_q != b_q) nxt = btgt;
			OPC_BLEZ: begin
				if (rt != 5'd0) flt = FLT_UNKNOWN;
				else if (a_q[31] || a_q == 32'd0) nxt = btgt;
			end
			OPC_BGTZ: begin
				if (rt != 5'd0) flt = FLT_UNKNOWN;
				else if (!a_q[31] && a_q != 32'd0) nxt = btgt;
			end
			OPC_ADDI, OPC_ADDIU: begin wen = 1'b1; widx = rt; wv = a_q + simm; end
			OPC_SLTI: begin wen = 1'b1; widx = rt;
				wv = {31'd0, $signed(a_q) < $signed(simm)}; end
			OPC_SLTIU: begin wen = 1'b1; widx = rt; wv = {31'd0, a_q < simm}; end
			OPC_ANDI: begin wen = 1'b1; widx = rt; wv = a_q & zimm; end
			OPC_ORI: begin wen = 1'b1; widx = rt; wv = a_q | zimm; end
			OPC_XORI: begin wen = 1'b1; widx = rt; wv = a_q ^ zimm; end
			OPC_LUI: begin wen = 1'b1; widx = rt; wv = {ins_q[15:0], 16'd0}; end
			OPC_LW: begin wen = 1'b1; widx = rt; wv = mrd_q; end
			OPC_LH, OPC_LHU: begin
				wen = 1'b1; widx = rt;
				lval = mrd_q >> {lo2_q[1], 4'd0};
				wv = opc[2] ? {16'd0, lval[15:0]} : {{16{lval[15]}}, lval[15:0]};
			end
			OPC_LB, OPC_LBU: begin
				wen = 1'b1; widx = rt;
				lval = mrd_q >> lane;
				wv = opc[2] ? {24'd0, lval[7:0]} : {{24{lval[7]}}, lval[7:0]};
			end
			OPC_SW: mwe = 1'b1;
			OPC_SH: begin
				mwe = 1'b1;
				memw = (mrd_q & ~(32'h0000_ffff << {lo2_q[1], 4'd0})) |
					({16'd0, b_q[15:0]} << {lo2_q[1], 4'd0});
			end
			OPC_SB: begin
				mwe = 1'b1;
				memw = (mrd_q & ~(32'h0000_00ff << lane)) | ({24'd0, b_q[7:0]} << lane);
			end
			default: flt = FLT_UNKNOWN;
		endcase
		if (flt == FLT_UNKNOWN) begin
			nxt = pc_q;
			wen = 1'b0;
		end
		if (widx == 5'd0) wen = 1'b0;
	end

	logic exec_now;
	assign exec_now = (state_q == ST_DONE) && (op_q == OP_EXEC) && !stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= 32'h0040_0000;
			hi_q <= '0;
			lo_q <= '0;
			stop_q <= 1'b0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) pc_q <= cfg_data;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (state_q == ST_MDU && md_stat.done) begin
				hi_q <= md_stat.hi;
				lo_q <= md_stat.lo;
			end
			if (state_q == ST_DONE) m_tvalid <= 1'b1;
			if (exec_now) begin
				pc_q <= nxt;
				if (hwe) hi_q <= a_q;
				if (lwe) lo_q <= a_q;
				if (halt_set) stop_q <= 1'b1;
				if (wen) rf_q[widx] <= wv;
			end
		end
	end

	// capture the transaction and read operands (rs and rt of the instruction word)
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= s_tdata[1:0];
			ins_q <= s_tdata[33:2];
			daddr_q <= s_tdata[65:34];
			dword_q <= s_tdata[97:66];
			a_q <= rf_q[s_tdata[27:23]];
			b_q <= rf_q[s_tdata[22:18]];
		end
		if (state_q == ST_DECODE) begin
			if (op_q == OP_EXEC) begin
				wi_q <= addr[DW_BITS+1:2];
				lo2_q <= addr[1:0];
			end else begin
				wi_q <= daddr_q[DW_BITS+1:2];
			end
		end
	end

	// data store: one port, read data registered
	always_ff @(posedge clk) begin
		if (state_q == ST_DECODE && op_q == OP_WRITE)
			mem[daddr_q[DW_BITS+1:2]] <= dword_q;
		else if (exec_now && mwe)
			mem[wi_q] <= memw;
		if (state_q == ST_MEM)
			mrd_q <= mem[wi_q];
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			o_pc_q <= exec_now ? nxt : pc_q;
			o_halt_q <= stop_q | (exec_now & halt_set);
			o_flt_q <= exec_now ? flt : FLT_NONE;
			o_wr_q <= exec_now & wen;
			o_ri_q <= (exec_now & wen) ? widx : 5'd0;
			o_rv_q <= (exec_now & wen) ? wv : 32'd0;
			o_rw_q <= (op_q == OP_READ) ? mrd_q : 32'd0;
		end
	end

	assign m_tdata = {7'd0, o_rw_q, o_rv_q, o_ri_q, o_wr_q, o_flt_q, o_halt_q, o_pc_q};
endmodule
`default_nettype wire
